// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, removed when the design is synthesised
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_IMPL(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ----- design/lhbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lhbp_pkg
// shared constants and types of the local history branch predictor
// ----------------------------------------------------------------------------
package lhbp_pkg;

  // default table geometry
  localparam int LHT_INDEX_BITS_DEF = 10;
  localparam int HIST_LEN_DEF       = 10;
  localparam int PHT_INDEX_BITS_DEF = 10;

  // stream widths
  localparam int ADDR_W     = 32;
  localparam int S_TDATA_W  = 40;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  // mode codes
  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_TRAIN   = 1'b1;

  // two-bit saturating counter codes
  localparam logic [1:0] CTR_MIN       = 2'd0;
  localparam logic [1:0] CTR_RESET     = 2'd1;
  localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;
  localparam logic [1:0] CTR_MAX       = 2'd3;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_CTR
  } back_state_t;

  // status from back to front
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ----- design/lhbp_queue.sv -----
// ----------------------------------------------------------------------------
// lhbp_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module lhbp_queue #(
  parameter int WIDTH = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import lhbp_pkg::*;

  logic [WIDTH-1:0]       entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_data;
  end

  assign rd_data = entries[rd_ptr];
  assign full    = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);

endmodule

// ----- design/lhbp_front.sv -----
// ----------------------------------------------------------------------------
// lhbp_front
// input side: accepts transfers and reduces them to queue entries
// ----------------------------------------------------------------------------
module lhbp_front #(
  parameter int LHT_INDEX_BITS = 10
) (
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: [31:0] branch_address, [32] outcome, [39:33] zero
  input  logic [lhbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: [0] mode
  input  logic [lhbp_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input  lhbp_pkg::back_status_t        status,
  input  logic                          q_full,
  output logic                          q_push,
  // entry: [LHT_INDEX_BITS-1:0] history index, then outcome, then train flag
  output logic [LHT_INDEX_BITS+1:0]     q_data
);
  import lhbp_pkg::*;

  logic                      train;
  logic                      taken;
  logic [LHT_INDEX_BITS-1:0] hidx;

  // hold off while the tables are being cleared or the queue is full
  assign s_axis_tready = !status.clearing && !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  // classify: train or predict, and which history entry the branch owns
  assign train  = (s_axis_tuser[0] == MODE_TRAIN);
  assign taken  = train && s_axis_tdata[ADDR_W];
  assign hidx   = s_axis_tdata[LHT_INDEX_BITS-1:0];
  assign q_data = {train, taken, hidx};

endmodule

// ----- design/lhbp_back.sv -----
// ----------------------------------------------------------------------------
// lhbp_back
// execution side: history and counter tables, update and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lhbp_back #(
  parameter int LHT_INDEX_BITS = 10,
  parameter int HIST_LEN       = 10,
  parameter int PHT_INDEX_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  logic [LHT_INDEX_BITS+1:0]      q_data,
  output logic                           q_pop,
  output lhbp_pkg::back_status_t         status,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: [0] predicted_taken, [7:1] zero
  output logic [lhbp_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import lhbp_pkg::*;

  localparam int LHT_DEPTH = 1 << LHT_INDEX_BITS;
  localparam int PHT_DEPTH = 1 << PHT_INDEX_BITS;
  localparam int CLR_W     = (LHT_INDEX_BITS > PHT_INDEX_BITS) ?
                             LHT_INDEX_BITS : PHT_INDEX_BITS;

  // tables
  logic [HIST_LEN-1:0] hist_mem [LHT_DEPTH];
  logic [1:0]          ctr_mem  [PHT_DEPTH];

  // sequencer and item registers
  back_state_t               st, st_next;
  logic [CLR_W-1:0]          clr_idx;
  logic                      train;
  logic                      taken;
  logic [LHT_INDEX_BITS-1:0] hidx;
  logic [PHT_INDEX_BITS-1:0] cidx;
  logic [HIST_LEN-1:0]       hist_rd;
  logic [1:0]                ctr_rd;
  logic                      out_valid;
  logic                      out_pred;

  // table port controls
  logic                      hist_we, hist_re, ctr_we, ctr_re;
  logic [LHT_INDEX_BITS-1:0] hist_waddr, hist_raddr;
  logic [HIST_LEN-1:0]       hist_wdata;
  logic [PHT_INDEX_BITS-1:0] ctr_waddr, ctr_raddr;
  logic [1:0]                ctr_wdata;

  logic                      out_free;
  logic                      clr_last;
  logic [PHT_INDEX_BITS-1:0] hist_cidx;
  logic [HIST_LEN:0]         hist_shift;
  logic [1:0]                ctr_upd;
  logic                      load_out;

  // counter index from the history, truncated or zero extended
  generate
    if (HIST_LEN >= PHT_INDEX_BITS) begin : g_cidx_trunc
      assign hist_cidx = hist_rd[PHT_INDEX_BITS-1:0];
    end else begin : g_cidx_ext
      assign hist_cidx = {{(PHT_INDEX_BITS-HIST_LEN){1'b0}}, hist_rd};
    end
  endgenerate

  // new history and saturating counter value
  assign hist_shift = {hist_rd, taken};
  always_comb begin
    ctr_upd = ctr_rd;
    if (taken) begin
      if (ctr_rd != CTR_MAX) ctr_upd = ctr_rd + 2'd1;
    end else begin
      if (ctr_rd != CTR_MIN) ctr_upd = ctr_rd - 2'd1;
    end
  end

  assign out_free = !out_valid || m_axis_tready;
  assign clr_last = &clr_idx;

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ST_CLEAR: if (clr_last) st_next = ST_IDLE;
      ST_IDLE:  if (!q_empty && out_free) st_next = ST_HIST;
      ST_HIST:  st_next = ST_CTR;
      ST_CTR:   st_next = ST_IDLE;
      default:  st_next = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop      = 1'b0;
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    ctr_we     = 1'b0;
    ctr_re     = 1'b0;
    hist_waddr = hidx;
    hist_wdata = hist_shift[HIST_LEN-1:0];
    hist_raddr = q_data[LHT_INDEX_BITS-1:0];
    ctr_waddr  = cidx;
    ctr_wdata  = ctr_upd;
    ctr_raddr  = hist_cidx;
    load_out   = 1'b0;
    status.clearing = 1'b0;
    case (st)
      ST_CLEAR: begin
        status.clearing = 1'b1;
        hist_we    = 1'b1;
        ctr_we     = 1'b1;
        hist_waddr = clr_idx[LHT_INDEX_BITS-1:0];
        hist_wdata = '0;
        ctr_waddr  = clr_idx[PHT_INDEX_BITS-1:0];
        ctr_wdata  = CTR_RESET;
      end
      ST_IDLE: begin
        q_pop   = !q_empty && out_free;
        hist_re = q_pop;
      end
      ST_HIST: begin
        ctr_re = 1'b1;
      end
      ST_CTR: begin
        load_out = 1'b1;
        hist_we  = train;
        ctr_we   = train;
      end
      default: begin
        status.clearing = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (load_out) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hidx  <= q_data[LHT_INDEX_BITS-1:0];
      taken <= q_data[LHT_INDEX_BITS];
      train <= q_data[LHT_INDEX_BITS+1];
    end
    if (ctr_re) cidx <= hist_cidx;
    if (load_out) out_pred <= (ctr_rd >= CTR_TAKEN_MIN);
  end

  // history table
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (hist_re) hist_rd <= hist_mem[hist_raddr];
  end

  // counter table
  always_ff @(posedge clk) begin
    if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
    if (ctr_re) ctr_rd <= ctr_mem[ctr_raddr];
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, out_pred};

  // checks
  `ASSERT_IMPL(a_out_free_at_load, clk, rst, (st == ST_CTR) |-> !out_valid)
  `ASSERT_NEVER(a_no_pop_in_clear, clk, rst, (st == ST_CLEAR) && q_pop)
  `ASSERT_IMPL(a_pop_starts_item, clk, rst, q_pop |=> (st == ST_HIST))
  `ASSERT_IMPL(a_result_follows, clk, rst, (st == ST_CTR) |=> out_valid)

endmodule

// ----- design/local_history_branch_predictor_unit.sv -----
// Path: a result passes through the queue, the history table read, the counter table
// read and the result register, then is held until taken. Items are handled one at
// a time: the next is popped after the update, once the result register is free.
// Reset: synchronous; afterwards a clearing pass over every entry of both tables
// runs with s_axis_tready low.
// ----------------------------------------------------------------------------
// local_history_branch_predictor_unit
// two-level local branch predictor with decoupled front, queue and back
// ----------------------------------------------------------------------------
module local_history_branch_predictor_unit #(
  parameter int LHT_INDEX_BITS = lhbp_pkg::LHT_INDEX_BITS_DEF,
  parameter int HIST_LEN       = lhbp_pkg::HIST_LEN_DEF,
  parameter int PHT_INDEX_BITS = lhbp_pkg::PHT_INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: [31:0] branch_address, [32] outcome, [39:33] zero
  input  logic [lhbp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: [0] mode
  input  logic [lhbp_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: [0] predicted_taken, [7:1] zero
  output logic [lhbp_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import lhbp_pkg::*;

  localparam int ENTRY_W = LHT_INDEX_BITS + 2;

  logic               q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0] q_wr_data, q_rd_data;
  back_status_t       status;

  // accept and classify
  lhbp_front #(
    .LHT_INDEX_BITS(LHT_INDEX_BITS)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .status       (status),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wr_data)
  );

  // decoupling queue
  lhbp_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_data(q_wr_data),
    .full   (q_full),
    .pop    (q_pop),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  // tables, update and result
  lhbp_back #(
    .LHT_INDEX_BITS(LHT_INDEX_BITS),
    .HIST_LEN      (HIST_LEN),
    .PHT_INDEX_BITS(PHT_INDEX_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_rd_data),
    .q_pop        (q_pop),
    .status       (status),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
